// ===== sv/usd_pkg.sv =====
// Constants shared by the ultrasonic speed detector.
`default_nettype none

package usd_pkg;

    // field widths
    localparam int unsigned WIDTH_W = 17;
    localparam int unsigned DIST_W  = 20;
    localparam int unsigned SPEED_W = 18;
    localparam int unsigned FINE_W  = 22;

    // configuration port
    localparam int unsigned CFG_W     = 20;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 1'b1;

    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST    = 18'd25600;
    localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RST = 20'd6400;

    // width*256/58 == width*ceil(2^29/29) >> 22, exact for 17-bit widths
    localparam int unsigned DIST_RECIP_W = 25;
    localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 25'd18512791;
    localparam int unsigned DIST_PROD_W = WIDTH_W + DIST_RECIP_W;
    localparam int unsigned DIST_SHIFT  = 22;

    // y/10 == y*ceil(2^30/10) >> 30, exact for y < 2^26
    localparam int unsigned SPD_Y_W     = 26;
    localparam int unsigned SPD_RECIP_W = 27;
    localparam logic [SPD_RECIP_W-1:0] SPD_RECIP = 27'd107374183;
    localparam int unsigned SPD_PROD_W  = SPD_Y_W + SPD_RECIP_W;
    localparam int unsigned SPD_SHIFT   = 30;
    localparam int unsigned SPD_Q_W     = SPD_PROD_W - SPD_SHIFT;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 18'h3FFFF;

endpackage

`default_nettype wire

// ===== sv/ultrasonic_speed_detector.sv =====
// Top level: echo width to distance, moving average, approach speed and limit check.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_echo_width_us
//  result  | out       | o_out_valid / i_out_ready | o_filtered_distance, o_speed_value,
//          |           |                           | o_fine_amount, o_approaching, o_over_limit
//  config  | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Six register stages: distance, tap line and running sum, average, tracker,
// speed, result. One beat enters per cycle unless the pipeline is stalled. Each
// stage advances when it is empty or the next one moves, so bubbles fill while a
// finished result waits on i_out_ready.
// Synchronous active-low reset clears the tap line, running sum, tracker,
// stage valid bits and loads the register defaults.
`default_nettype none

module ultrasonic_speed_detector #(
    parameter int unsigned TAPS = 10
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [usd_pkg::WIDTH_W-1:0]         i_echo_width_us,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [usd_pkg::DIST_W-1:0]          o_filtered_distance,
    output logic [usd_pkg::SPEED_W-1:0]         o_speed_value,
    output logic [usd_pkg::FINE_W-1:0]          o_fine_amount,
    output logic                                o_approaching,
    output logic                                o_over_limit,
    input  wire                                 i_cfg_we,
    input  wire  [usd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [usd_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int unsigned DIST_W  = usd_pkg::DIST_W;
    localparam int unsigned SPEED_W = usd_pkg::SPEED_W;
    localparam int unsigned FINE_W  = usd_pkg::FINE_W;
    localparam int unsigned SUM_W   = DIST_W + $clog2(TAPS);
    // sum/TAPS as a reciprocal multiply, exact for any sum below 2^SUM_W
    localparam int unsigned FK      = SUM_W + $clog2(TAPS);
    localparam logic [FK-1:0] FILT_RECIP =
        FK'(((64'd1 << FK) + 64'(TAPS) - 64'd1) / 64'(TAPS));
    localparam int unsigned FPROD_W = SUM_W + FK;

    // configuration
    logic [SPEED_W-1:0] r_speed_limit;
    logic [DIST_W-1:0]  r_near_threshold;

    // stage valid bits and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6;

    // stage payloads and state
    logic [DIST_W-1:0]  r1_dist;
    logic [DIST_W-1:0]  r_taps [TAPS];
    logic [SUM_W-1:0]   r_sum;
    logic [DIST_W-1:0]  r3_filt;
    logic [DIST_W-1:0]  r_prev;
    logic [DIST_W-1:0]  r_cur;
    logic [DIST_W-1:0]  r4_filt;
    logic [DIST_W-1:0]  r4_diff;
    logic               r4_appr;
    logic [DIST_W-1:0]  r5_filt;
    logic [SPEED_W-1:0] r5_speed;
    logic               r5_appr;
    logic [DIST_W-1:0]  r6_filt;
    logic [SPEED_W-1:0] r6_speed;
    logic [FINE_W-1:0]  r6_fine;
    logic               r6_appr;
    logic               r6_over;

    // combinational
    logic [usd_pkg::DIST_PROD_W-1:0] w_dist_prod;
    logic [DIST_W-1:0]               w_dist;
    logic [SUM_W-1:0]                n_sum;
    logic [FPROD_W-1:0]              w_filt_prod;
    logic                            w_near;
    logic [DIST_W-1:0]               n_prev;
    logic [DIST_W-1:0]               n_cur;
    logic [usd_pkg::SPD_Y_W-1:0]     w_spd_y;
    logic [usd_pkg::SPD_PROD_W-1:0]  w_spd_prod;
    logic [usd_pkg::SPD_Q_W-1:0]     w_spd_q;
    logic [SPEED_W-1:0]              w_speed;
    logic                            w_over;

    // ready ripples back from the result register
    assign w_en6 = !r_v6 || i_out_ready;
    assign w_en5 = !r_v5 || w_en6;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_in_ready = w_en1;

    // stage 1: width to Q.8 cm
    assign w_dist_prod = usd_pkg::DIST_PROD_W'(i_echo_width_us)
                       * usd_pkg::DIST_PROD_W'(usd_pkg::DIST_RECIP);
    assign w_dist = w_dist_prod[usd_pkg::DIST_SHIFT +: DIST_W];

    // stage 2: drop the oldest tap, add the newest
    assign n_sum = r_sum - SUM_W'(r_taps[0]) + SUM_W'(r1_dist);

    // stage 3: average
    assign w_filt_prod = FPROD_W'(r_sum) * FPROD_W'(FILT_RECIP);

    // stage 4: tracker
    assign w_near = (r3_filt <= r_near_threshold);
    assign n_prev = w_near ? r_cur : r_prev;
    assign n_cur  = w_near ? r3_filt : r_cur;

    // stage 5: speed = diff*33/10, saturated
    assign w_spd_y    = (usd_pkg::SPD_Y_W'(r4_diff) << 5) + usd_pkg::SPD_Y_W'(r4_diff);
    assign w_spd_prod = usd_pkg::SPD_PROD_W'(w_spd_y)
                      * usd_pkg::SPD_PROD_W'(usd_pkg::SPD_RECIP);
    assign w_spd_q    = w_spd_prod[usd_pkg::SPD_SHIFT +: usd_pkg::SPD_Q_W];
    assign w_speed    = (w_spd_q > usd_pkg::SPD_Q_W'(usd_pkg::SPEED_MAX))
                      ? usd_pkg::SPEED_MAX : w_spd_q[SPEED_W-1:0];

    // stage 6: limit check
    assign w_over = r5_appr && (r5_speed >= r_speed_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit    <= usd_pkg::SPEED_LIMIT_RST;
            r_near_threshold <= usd_pkg::NEAR_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                usd_pkg::CFG_SPEED_LIMIT: begin
                    r_speed_limit <= i_cfg_data[SPEED_W-1:0];
                end
                usd_pkg::CFG_NEAR_THRESHOLD: begin
                    r_near_threshold <= i_cfg_data[DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
            if (w_en6) r_v6 <= r_v5;
        end
    end

    // filter and tracker state move only when a beat enters their stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_taps[i] <= '0;
            end
            r_sum  <= '0;
            r_prev <= '0;
            r_cur  <= '0;
        end else begin
            if (w_en2 && r_v1) begin
                for (int i = 0; i < TAPS - 1; i++) begin
                    r_taps[i] <= r_taps[i+1];
                end
                r_taps[TAPS-1] <= r1_dist;
                r_sum          <= n_sum;
            end
            if (w_en4 && r_v3) begin
                r_prev <= n_prev;
                r_cur  <= n_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in_valid) begin
            r1_dist <= w_dist;
        end
        if (w_en3 && r_v2) begin
            r3_filt <= w_filt_prod[FK +: DIST_W];
        end
        if (w_en4 && r_v3) begin
            r4_filt <= r3_filt;
            r4_appr <= (n_prev > n_cur);
            r4_diff <= (n_prev > n_cur) ? (n_prev - n_cur) : '0;
        end
        if (w_en5 && r_v4) begin
            r5_filt  <= r4_filt;
            r5_speed <= w_speed;
            r5_appr  <= r4_appr;
        end
        if (w_en6 && r_v5) begin
            r6_filt  <= r5_filt;
            r6_speed <= r5_speed;
            r6_appr  <= r5_appr;
            r6_over  <= w_over;
            r6_fine  <= w_over ? ((FINE_W'(r5_speed) << 3) + (FINE_W'(r5_speed) << 1))
                               : '0;
        end
    end

    assign o_out_valid         = r_v6;
    assign o_filtered_distance = r6_filt;
    assign o_speed_value       = r6_speed;
    assign o_fine_amount       = r6_fine;
    assign o_approaching       = r6_appr;
    assign o_over_limit        = r6_over;

    a_over_needs_approach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_over_limit |-> o_approaching)
        else $error("over_limit without approach");

    a_idle_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_approaching |-> o_speed_value == '0 && o_fine_amount == '0)
        else $error("speed or fine set while not approaching");

    a_fine_is_ten_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_over_limit |->
            o_fine_amount == (FINE_W'(o_speed_value) * FINE_W'(10)))
        else $error("fine is not ten times speed");

    a_full_pipe_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_v6 && !i_out_ready |-> !o_in_ready)
        else $error("input accepted into a full stalled pipeline");

endmodule

`default_nettype wire
